### rtl/gsa_pkg.sv
// Shared types and codes for the generational slot allocator.
package gsa_pkg;

    // Request command codes.
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Field widths of one request and one result.
    localparam int CMD_W    = 2;
    localparam int HIDX_W   = 4;
    localparam int HGEN_W   = 16;
    localparam int STATUS_W = 2;
    localparam int TDATA_W  = 24;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic lookup;
        logic execute;
    } gsa_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } gsa_stat_t;

endpackage

### rtl/gsa_ctrl.sv
// Request sequencer for the generational slot allocator.
module gsa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  gsa_pkg::gsa_stat_t stat,
    output gsa_pkg::gsa_ctrl_t ctrl
);
    import gsa_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.lookup  = 1'b0;
        ctrl.execute = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.capture = 1'b1;
                    state_next   = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                ctrl.lookup = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC: begin
                // Commit only once the result register can take the beat.
                if (stat.out_free) begin
                    ctrl.execute = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");
    a_lookup_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.lookup |=> (state_reg == S_EXEC))
        else $error("lookup not followed by execute state");
    a_exec_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.execute |-> stat.out_free)
        else $error("result committed while output register is full");
`endif

endmodule

### rtl/gsa_datapath.sv
// Slot tables, free stack, counters and result register of the allocator.
module gsa_datapath #(
    parameter int SLOTS    = 16,
    parameter int GEN_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  gsa_pkg::gsa_ctrl_t             ctrl,
    output gsa_pkg::gsa_stat_t             stat,
    input  logic [gsa_pkg::CMD_W-1:0]      in_command,
    input  logic [gsa_pkg::HIDX_W-1:0]     in_handle_index,
    input  logic [gsa_pkg::HGEN_W-1:0]     in_handle_generation,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gsa_pkg::STATUS_W-1:0]   out_status,
    output logic [gsa_pkg::HIDX_W-1:0]     out_index,
    output logic [gsa_pkg::HGEN_W-1:0]     out_generation
);
    import gsa_pkg::*;

    localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW  = IW + 1;
    localparam int XW  = (CW > HIDX_W) ? CW : HIDX_W;
    localparam int GCW = (GEN_BITS > HGEN_W) ? GEN_BITS : HGEN_W;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    // Storage.
    logic [GEN_BITS-1:0] gen_mem [SLOTS];
    logic [IW-1:0]       stack_mem [SLOTS];
    logic [SLOTS-1:0]    alive_reg;
    logic [CW-1:0]       free_count_reg;
    logic [CW-1:0]       used_count_reg;

    // Request held across the sequence.
    logic [CMD_W-1:0]    cmd_reg;
    logic [XW-1:0]       hidx_reg;
    logic [HGEN_W-1:0]   hgen_reg;
    logic [IW-1:0]       stack_q_reg;
    logic [IW-1:0]       slot_reg;
    logic [GEN_BITS-1:0] gen_q_reg;
    logic                alive_q_reg;
    logic                in_range_reg;

    // Result register.
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [HIDX_W-1:0]   oidx_reg;
    logic [HGEN_W-1:0]   ogen_reg;

    logic [CW-1:0]       free_top;
    logic [IW-1:0]       lookup_addr;
    logic                live;
    logic                alloc_pop;
    logic                alloc_new;
    logic                free_ok;
    logic [GEN_BITS-1:0] gen_inc;
    logic [IW-1:0]       wr_slot;
    logic [GEN_BITS-1:0] wr_gen;
    logic                gen_we;
    logic [STATUS_W-1:0] status_next;
    logic [XW-1:0]       oidx_wide;
    logic [GCW-1:0]      ogen_wide;
    logic [GCW-1:0]      gen_q_wide;
    logic [GCW-1:0]      hgen_wide;

    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign free_top    = free_count_reg - CW'(1);
    assign lookup_addr = (cmd_reg == CMD_ALLOC) ? stack_q_reg : hidx_reg[IW-1:0];

    assign gen_q_wide = GCW'(gen_q_reg);
    assign hgen_wide  = GCW'(hgen_reg);
    assign live       = in_range_reg && alive_q_reg && (gen_q_wide == hgen_wide);
    assign gen_inc    = gen_q_reg + GEN_BITS'(1);

    assign alloc_pop = (cmd_reg == CMD_ALLOC) && (free_count_reg != '0);
    assign alloc_new = (cmd_reg == CMD_ALLOC) && (free_count_reg == '0)
                       && (used_count_reg != SLOTS_C);
    assign free_ok   = (cmd_reg == CMD_FREE) && live && (free_count_reg != SLOTS_C);

    always_comb begin
        priority if (alloc_new) begin
            wr_slot = used_count_reg[IW-1:0];
            wr_gen  = '0;
        end else begin
            wr_slot = slot_reg;
            wr_gen  = gen_inc;
        end
        gen_we = ctrl.execute && (alloc_pop || alloc_new || free_ok);
    end

    always_comb begin
        unique case (cmd_reg)
            CMD_ALLOC: status_next = (alloc_pop || alloc_new) ? ST_OK : ST_FULL;
            CMD_FREE:  status_next = free_ok ? ST_OK : ST_INVALID;
            CMD_CHECK: status_next = live ? ST_OK : ST_INVALID;
            default:   status_next = ST_INVALID;
        endcase
    end

    assign oidx_wide = XW'(wr_slot);
    assign ogen_wide = GCW'(wr_gen);

    // Memories: registered reads, one write port each.
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            stack_q_reg <= stack_mem[free_top[IW-1:0]];
        end
        if (ctrl.lookup) begin
            gen_q_reg <= gen_mem[lookup_addr];
        end
        if (gen_we) begin
            gen_mem[wr_slot] <= wr_gen;
        end
        if (ctrl.execute && free_ok) begin
            stack_mem[free_count_reg[IW-1:0]] <= slot_reg;
        end
    end

    // Request capture and lookup results; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg  <= in_command;
            hidx_reg <= XW'(in_handle_index);
            hgen_reg <= in_handle_generation;
        end
        if (ctrl.lookup) begin
            slot_reg     <= lookup_addr;
            alive_q_reg  <= alive_reg[lookup_addr];
            in_range_reg <= hidx_reg < XW'(used_count_reg);
        end
        if (ctrl.execute) begin
            status_reg <= status_next;
            if (alloc_pop || alloc_new) begin
                oidx_reg <= oidx_wide[HIDX_W-1:0];
                ogen_reg <= ogen_wide[HGEN_W-1:0];
            end else begin
                oidx_reg <= '0;
                ogen_reg <= '0;
            end
        end
    end

    // Control state: counters, alive bits and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg      <= '0;
            free_count_reg <= '0;
            used_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (ctrl.execute) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (ctrl.execute) begin
                if (alloc_pop) begin
                    alive_reg[wr_slot] <= 1'b1;
                    free_count_reg     <= free_count_reg - CW'(1);
                end else if (alloc_new) begin
                    alive_reg[wr_slot] <= 1'b1;
                    used_count_reg     <= used_count_reg + CW'(1);
                end else if (free_ok) begin
                    alive_reg[wr_slot] <= 1'b0;
                    free_count_reg     <= free_count_reg + CW'(1);
                end
            end
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign out_status     = status_reg;
    assign out_index      = oidx_reg;
    assign out_generation = ogen_reg;

`ifndef SYNTH
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_count_reg <= SLOTS_C)
        else $error("more slots appended than the pool holds");
    a_free_le_used: assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= used_count_reg)
        else $error("free stack deeper than the appended slots");
    a_slot_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(alive_reg) + int'(free_count_reg)) == int'(used_count_reg))
        else $error("alive slots and free stack do not add up to appended slots");
`endif

endmodule

### rtl/generational_slot_allocator_top.sv
// An accepted request steps through lookup and execute; its result beat is valid
// once the commit registers it. A new request is accepted only after the commit;
// the free-stack read, the generation read and the commit are done in turn.
// A pending result beat does not block acceptance; the commit waits for it.
// Reset (aresetn low, synchronous) empties the pool: no slot alive, counters zero.
// Top level of the generational slot allocator.
module generational_slot_allocator_top #(
    parameter int SLOTS    = 16,
    parameter int GEN_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command [1:0], handle_index [5:2], handle_generation [21:6], zero [23:22]
    input  logic [gsa_pkg::TDATA_W-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [1:0], out_index [5:2], out_generation [21:6], zero [23:22]
    output logic [gsa_pkg::TDATA_W-1:0]   m_tdata
);
    import gsa_pkg::*;

    gsa_ctrl_t           ctrl;
    gsa_stat_t           stat;
    logic [STATUS_W-1:0] out_status;
    logic [HIDX_W-1:0]   out_index;
    logic [HGEN_W-1:0]   out_generation;

    gsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    gsa_datapath #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .ctrl                 (ctrl),
        .stat                 (stat),
        .in_command           (s_tdata[1:0]),
        .in_handle_index      (s_tdata[5:2]),
        .in_handle_generation (s_tdata[21:6]),
        .m_tvalid             (m_tvalid),
        .m_tready             (m_tready),
        .out_status           (out_status),
        .out_index            (out_index),
        .out_generation       (out_generation)
    );

    assign m_tdata = {2'b00, out_generation, out_index, out_status};

endmodule
